@@ sv/rle_pkg.sv @@
// Shared constants and types for the PackBits-style byte run-length encoder.
// No dependencies; imported by the encoder top level and its checker.
`default_nettype none

package rle_pkg;

    // Packet limits and output packing
    localparam int MAX_RUN        = 127;
    localparam int MAX_LITERAL    = 128;
    localparam int BYTES_PER_WORD = 8;

    // Derived widths
    localparam int RUN_W      = $clog2(MAX_RUN + 1);
    localparam int LIT_AW     = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;
    localparam int LIT_LW     = $clog2(MAX_LITERAL + 1);
    localparam int BYTE_SEL_W = (BYTES_PER_WORD > 1) ? $clog2(BYTES_PER_WORD) : 1;

    // Fixed field widths of the ports
    localparam int DATA_W  = 8;
    localparam int WORD_W  = 64;
    localparam int COUNT_W = 4;

    // Header flag of a run packet
    localparam logic [DATA_W-1:0] RUN_FLAG = 8'h80;

    typedef logic [DATA_W-1:0]  t_byte;
    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [COUNT_W-1:0] t_count;

endpackage

`default_nettype wire

@@ sv/rle_byte_encoder_top.sv @@
// PackBits-style run-length encoder: sequencer, literal store and output word packer.
// Depends on rle_pkg.
`default_nettype none

// One input byte per beat; the block holds one byte of lookahead, so a byte is
// encoded once its successor or the end of the stream is known. Runs of 2 to 127
// equal bytes come out as {0x80+length, byte}; other bytes as a literal packet
// {length-1, 1 to 128 raw bytes}. Encoded bytes are packed eight to an output
// beat, earliest byte lowest; item_done marks the last beat caused by an input
// byte and stream_done the last beat of a stream. Every encoded byte passes
// through one byte-wide emit path, one byte per cycle while the output is not
// stalled, and literal bytes are read back, likewise one per cycle, from a store
// with one write port and one registered read port. o_stall is high from the
// cycle after acceptance until the block is ready again.
module rle_byte_encoder_top (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // input channel
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire rle_pkg::t_byte  i_data_byte,
    input  wire                  i_end_of_stream,
    // output channel
    output logic                 o_valid,
    input  wire                  i_stall,
    output rle_pkg::t_word       o_out_word,
    output rle_pkg::t_count      o_out_bytes,
    output logic                 o_item_done,
    output logic                 o_stream_done
);
    import rle_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECIDE   = 3'd1;
    localparam logic [2:0] S_RUN_HDR  = 3'd2;
    localparam logic [2:0] S_RUN_BYTE = 3'd3;
    localparam logic [2:0] S_LIT_HDR  = 3'd4;
    localparam logic [2:0] S_LIT_DATA = 3'd5;
    localparam logic [2:0] S_FLUSH    = 3'd6;

    // Sequencer and encoder state
    logic [2:0]        r_state, n_state;
    logic              r_phase, n_phase;      // 0: byte step, 1: end-of-stream step
    t_byte             r_in_byte, n_in_byte;
    logic              r_eos, n_eos;
    t_byte             r_held, n_held;
    logic              r_held_valid, n_held_valid;
    logic [RUN_W-1:0]  r_run, n_run;
    logic [LIT_AW-1:0] r_lit_cnt, n_lit_cnt;
    // Pending packet work for the current step
    logic              r_do_run, n_do_run;
    logic              r_do_lit, n_do_lit;
    t_byte             r_run_hdr, n_run_hdr;
    t_byte             r_run_byte, n_run_byte;
    logic [LIT_LW-1:0] r_lit_len, n_lit_len;
    logic [LIT_AW-1:0] r_lit_idx, n_lit_idx;
    // Word packer and output register
    t_word             r_pack, n_pack;
    t_count            r_pack_n, n_pack_n;
    logic              r_out_valid, n_out_valid;
    t_word             r_out_word, n_out_word;
    t_count            r_out_bytes, n_out_bytes;
    logic              r_out_item, n_out_item;
    logic              r_out_stream, n_out_stream;

    // Literal store
    t_byte             r_lit_mem [MAX_LITERAL];
    t_byte             r_rd_data;
    logic [LIT_AW-1:0] rd_addr;
    logic              wr_en;
    logic [LIT_AW-1:0] wr_addr;
    t_byte             wr_data;

    // Emit path
    logic              em_valid;
    t_byte             em_byte;
    logic              em_go;
    logic              out_free;
    logic              pack_full;
    logic              phase_end;
    logic              lit_last;

    assign out_free  = !r_out_valid || !i_stall;
    assign pack_full = (r_pack_n == COUNT_W'(BYTES_PER_WORD));
    assign lit_last  = (LIT_LW'(r_lit_idx) == r_lit_len - LIT_LW'(1));

    // Select the byte the sequencer offers this cycle
    always_comb begin
        em_valid = 1'b1;
        em_byte  = '0;
        unique case (r_state)
            S_RUN_HDR:  em_byte = r_run_hdr;
            S_RUN_BYTE: em_byte = r_run_byte;
            S_LIT_HDR:  em_byte = DATA_W'(r_lit_len - LIT_LW'(1));
            S_LIT_DATA: em_byte = r_rd_data;
            default:    em_valid = 1'b0;
        endcase
    end

    // A byte moves when the packer has room or the full word can leave
    assign em_go = em_valid && (!pack_full || out_free);

    // Next-state logic of sequencer, encoder state and packer
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_in_byte    = r_in_byte;
        n_eos        = r_eos;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_run        = r_run;
        n_lit_cnt    = r_lit_cnt;
        n_do_run     = r_do_run;
        n_do_lit     = r_do_lit;
        n_run_hdr    = r_run_hdr;
        n_run_byte   = r_run_byte;
        n_lit_len    = r_lit_len;
        n_lit_idx    = r_lit_idx;
        n_pack       = r_pack;
        n_pack_n     = r_pack_n;
        n_out_valid  = r_out_valid && i_stall;
        n_out_word   = r_out_word;
        n_out_bytes  = r_out_bytes;
        n_out_item   = r_out_item;
        n_out_stream = r_out_stream;
        wr_en        = 1'b0;
        wr_addr      = r_lit_cnt;
        wr_data      = r_held;
        rd_addr      = r_lit_idx;
        phase_end    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_in_byte = i_data_byte;
                    n_eos     = i_end_of_stream;
                    n_phase   = 1'b0;
                    n_state   = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_do_run   = 1'b0;
                n_do_lit   = 1'b0;
                n_run_hdr  = RUN_FLAG | DATA_W'(r_run);
                n_run_byte = r_held;
                n_lit_len  = LIT_LW'(r_lit_cnt);
                if (!r_phase) begin
                    if (!r_held_valid) begin
                        // first byte of a stream: just hold it
                        n_held       = r_in_byte;
                        n_held_valid = 1'b1;
                        n_run        = RUN_W'(1);
                    end else if (r_in_byte == r_held) begin
                        if (r_run == RUN_W'(MAX_RUN)) begin
                            // run at maximum: emit it and start over
                            n_do_run = 1'b1;
                            n_run    = RUN_W'(1);
                        end else begin
                            n_run = r_run + RUN_W'(1);
                            // a run begins: close any pending literal
                            if (r_run == RUN_W'(1)) begin
                                n_do_lit  = (r_lit_cnt != '0);
                                n_lit_cnt = '0;
                            end
                        end
                    end else begin
                        if (r_run >= RUN_W'(2)) begin
                            n_do_run = 1'b1;
                        end else begin
                            // move the held byte into the literal
                            wr_en = 1'b1;
                            if (r_lit_cnt == LIT_AW'(MAX_LITERAL - 1)) begin
                                n_do_lit  = 1'b1;
                                n_lit_len = LIT_LW'(MAX_LITERAL);
                                n_lit_cnt = '0;
                            end else begin
                                n_lit_cnt = r_lit_cnt + LIT_AW'(1);
                            end
                        end
                        n_held = r_in_byte;
                        n_run  = RUN_W'(1);
                    end
                end else begin
                    // end of stream: commit everything held
                    if (r_run >= RUN_W'(2)) begin
                        n_do_run = 1'b1;
                        n_do_lit = (r_lit_cnt != '0);
                    end else begin
                        wr_en     = 1'b1;
                        n_do_lit  = 1'b1;
                        n_lit_len = LIT_LW'(r_lit_cnt) + LIT_LW'(1);
                    end
                    n_held       = '0;
                    n_held_valid = 1'b0;
                    n_run        = '0;
                    n_lit_cnt    = '0;
                end
                if (n_do_run) begin
                    n_state = S_RUN_HDR;
                end else if (n_do_lit) begin
                    n_state = S_LIT_HDR;
                end else begin
                    phase_end = 1'b1;
                end
            end

            S_RUN_HDR: begin
                if (em_go) begin
                    n_state = S_RUN_BYTE;
                end
            end

            S_RUN_BYTE: begin
                if (em_go) begin
                    if (r_do_lit) begin
                        n_state = S_LIT_HDR;
                    end else begin
                        phase_end = 1'b1;
                    end
                end
            end

            S_LIT_HDR: begin
                // prefetch the first literal byte
                rd_addr = '0;
                if (em_go) begin
                    n_lit_idx = '0;
                    n_state   = S_LIT_DATA;
                end
            end

            S_LIT_DATA: begin
                if (em_go) begin
                    rd_addr   = r_lit_idx + LIT_AW'(1);
                    n_lit_idx = r_lit_idx + LIT_AW'(1);
                    if (lit_last) begin
                        phase_end = 1'b1;
                    end
                end
            end

            S_FLUSH: begin
                // close the step with its last, partial or full, word
                if (r_pack_n == '0) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_word   = r_pack;
                    n_out_bytes  = r_pack_n;
                    n_out_item   = 1'b1;
                    n_out_stream = r_eos;
                    n_pack       = '0;
                    n_pack_n     = '0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // after a step's packets, run the end-of-stream step or close the item
        if (phase_end) begin
            if (!r_phase && r_eos) begin
                n_phase = 1'b1;
                n_state = S_DECIDE;
            end else begin
                n_state = S_FLUSH;
            end
        end

        // pack the emitted byte; a full word leaves only when another byte follows
        if (em_go) begin
            if (pack_full) begin
                n_out_valid  = 1'b1;
                n_out_word   = r_pack;
                n_out_bytes  = r_pack_n;
                n_out_item   = 1'b0;
                n_out_stream = 1'b0;
                n_pack       = WORD_W'(em_byte);
                n_pack_n     = COUNT_W'(1);
            end else begin
                n_pack   = r_pack | (WORD_W'(em_byte) << {r_pack_n[BYTE_SEL_W-1:0], 3'b000});
                n_pack_n = r_pack_n + COUNT_W'(1);
            end
        end
    end

    // Control and encoder registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= 1'b0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_run        <= '0;
            r_lit_cnt    <= '0;
            r_pack       <= '0;
            r_pack_n     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_run        <= n_run;
            r_lit_cnt    <= n_lit_cnt;
            r_pack       <= n_pack;
            r_pack_n     <= n_pack_n;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_in_byte    <= n_in_byte;
        r_eos        <= n_eos;
        r_do_run     <= n_do_run;
        r_do_lit     <= n_do_lit;
        r_run_hdr    <= n_run_hdr;
        r_run_byte   <= n_run_byte;
        r_lit_len    <= n_lit_len;
        r_lit_idx    <= n_lit_idx;
        r_out_word   <= n_out_word;
        r_out_bytes  <= n_out_bytes;
        r_out_item   <= n_out_item;
        r_out_stream <= n_out_stream;
    end

    // Literal store: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_lit_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_lit_mem[rd_addr];
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_out_word    = r_out_word;
    assign o_out_bytes   = r_out_bytes;
    assign o_item_done   = r_out_item;
    assign o_stream_done = r_out_stream;

endmodule

`default_nettype wire

@@ sv/rle_chk.sv @@
// Port-level checker for the run-length encoder, with its bind to the top level.
// Depends on rle_pkg and rle_byte_encoder_top.
`default_nettype none

module rle_chk (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  wire                  o_stall,
    input  wire rle_pkg::t_byte  i_data_byte,
    input  wire                  i_end_of_stream,
    input  wire                  o_valid,
    input  wire                  i_stall,
    input  wire rle_pkg::t_word  o_out_word,
    input  wire rle_pkg::t_count o_out_bytes,
    input  wire                  o_item_done,
    input  wire                  o_stream_done
);
    import rle_pkg::*;

    // a beat carries 1 to a full word of bytes
    a_bytes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_bytes != '0) && (o_out_bytes <= COUNT_W'(BYTES_PER_WORD)))
        else $error("output beat byte count out of range");

    // only the last beat of an item may be partial
    a_partial_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out_bytes != COUNT_W'(BYTES_PER_WORD))) |-> o_item_done)
        else $error("partial output beat without item_done");

    // stream end is always also an item end
    a_stream_implies_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stream_done) |-> o_item_done)
        else $error("stream_done without item_done");

    // an accepted byte keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after a beat was accepted");

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_word) && $stable(o_out_bytes)
                                  && $stable(o_item_done) && $stable(o_stream_done)))
        else $error("stalled output beat changed");

endmodule

bind rle_byte_encoder_top rle_chk u_rle_chk (.*);

`default_nettype wire

@@ verif/rle_checker.sv @@
// Checker for the run-length encoder: watches both channels, predicts the encoded
// output beats of every accepted input byte and compares them in order.
// Depends on rle_pkg.
module rle_checker
    import rle_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    // input channel as seen on the block's ports
    input  wire     i_in_valid,
    input  wire     i_in_stall,
    input  t_byte   i_data_byte,
    input  wire     i_end_of_stream,
    // output channel as seen on the block's ports
    input  wire     i_out_valid,
    input  wire     i_out_stall,
    input  t_word   i_out_word,
    input  t_count  i_out_bytes,
    input  wire     i_item_done,
    input  wire     i_stream_done,
    // status toward the testbench top
    output int      o_errors,
    output int      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_word  word;
        t_count nbytes;
        logic   item_done;
        logic   stream_done;
    } t_enc_beat;

    // Encoder state as the predictor tracks it
    t_byte              held_byte;
    logic               held_valid;
    logic [RUN_W-1:0]   run_len;
    t_byte              lit_store [MAX_LITERAL];
    logic [LIT_LW-1:0]  lit_count;

    t_byte      packet_bytes [$];
    t_enc_beat  expected_beats [$];
    t_enc_beat  want;

    // Append a run packet: header with the run flag, then the repeated byte
    task automatic emit_run_packet();
        packet_bytes.push_back(t_byte'(RUN_FLAG + run_len));
        packet_bytes.push_back(held_byte);
    endtask

    // Append the pending literal packet, if any, and empty the store
    task automatic flush_literal_packet();
        if (lit_count == 0) return;
        packet_bytes.push_back(t_byte'(lit_count - 1'b1));
        for (int i = 0; i < lit_count; i++) begin
            packet_bytes.push_back(lit_store[i]);
        end
        lit_count = '0;
    endtask

    // Add one byte to the literal; a full literal goes out at once
    task automatic push_literal_byte(input t_byte b);
        lit_store[lit_count[LIT_AW-1:0]] = b;
        lit_count = lit_count + 1'b1;
        if (lit_count >= MAX_LITERAL) flush_literal_packet();
    endtask

    // Advance the encoder by one input byte and queue the output beats it causes
    task automatic encode_byte(input t_byte b, input logic eos);
        int        nbeats;
        int        cnt;
        t_enc_beat beat;
        packet_bytes.delete();

        if (!held_valid) begin
            held_byte  = b;
            run_len    = 1;
            held_valid = 1'b1;
        end else if (b == held_byte) begin
            // a run at its maximum length goes out and a new run starts
            if (run_len >= MAX_RUN) begin
                emit_run_packet();
                run_len = 1;
            end else begin
                run_len = run_len + 1'b1;
                if (run_len == 2) flush_literal_packet();
            end
        end else begin
            if (run_len >= 2) emit_run_packet();
            else push_literal_byte(held_byte);
            held_byte = b;
            run_len   = 1;
        end

        // end of stream: commit everything held and return to the idle state
        if (eos) begin
            if (run_len >= 2) emit_run_packet();
            else push_literal_byte(held_byte);
            flush_literal_packet();
            held_byte  = '0;
            held_valid = 1'b0;
            run_len    = '0;
            lit_count  = '0;
        end

        // pack encoded bytes into output beats, earliest byte lowest
        nbeats = (packet_bytes.size() + BYTES_PER_WORD - 1) / BYTES_PER_WORD;
        for (int k = 0; k < nbeats; k++) begin
            cnt = packet_bytes.size() - k * BYTES_PER_WORD;
            if (cnt > BYTES_PER_WORD) cnt = BYTES_PER_WORD;
            beat.word = '0;
            for (int j = 0; j < cnt; j++) begin
                beat.word[8*j +: 8] = packet_bytes[k * BYTES_PER_WORD + j];
            end
            beat.nbytes      = t_count'(cnt);
            beat.item_done   = (k == nbeats - 1);
            beat.stream_done = (k == nbeats - 1) && eos;
            expected_beats.push_back(beat);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_byte  = '0;
            held_valid = 1'b0;
            run_len    = '0;
            lit_count  = '0;
            expected_beats.delete();
        end else begin
            // compare each accepted output beat with the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected output beat: out_word %h, out_bytes %0d",
                           i_out_word, i_out_bytes);
                    o_errors = o_errors + 1;
                end else begin
                    want = expected_beats.pop_front();
                    if (i_out_word !== want.word) begin
                        $error("out_word: expected %h, got %h", want.word, i_out_word);
                        o_errors = o_errors + 1;
                    end
                    if (i_out_bytes !== want.nbytes) begin
                        $error("out_bytes: expected %0d, got %0d", want.nbytes, i_out_bytes);
                        o_errors = o_errors + 1;
                    end
                    if (i_item_done !== want.item_done) begin
                        $error("item_done: expected %b, got %b", want.item_done, i_item_done);
                        o_errors = o_errors + 1;
                    end
                    if (i_stream_done !== want.stream_done) begin
                        $error("stream_done: expected %b, got %b",
                               want.stream_done, i_stream_done);
                        o_errors = o_errors + 1;
                    end
                end
            end
            // predict the beats of each accepted input byte
            if (i_in_valid && !i_in_stall) begin
                encode_byte(i_data_byte, i_end_of_stream);
            end
        end
        o_pending <= expected_beats.size();
    end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for the run-length encoder: clock, reset, byte-stream stimulus,
// output stall pattern, watchdog and verdict. Depends on rle_pkg, the encoder
// top level and rle_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rle_pkg::*;

    localparam int PERIOD         = 12;
    localparam int RANDOM_ITEMS   = 270;
    localparam int LONG_HOLD      = 600;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 3000;

    logic   clk           = 1'b0;
    logic   rst_n         = 1'b0;
    logic   in_valid      = 1'b0;
    t_byte  data_byte     = '0;
    logic   end_of_stream = 1'b0;
    logic   out_stall     = 1'b0;
    wire    in_stall;
    wire    out_valid;
    t_word  out_word;
    t_count out_bytes;
    wire    item_done;
    wire    stream_done;

    int     errors;
    int     pending;

    // sender side
    t_byte  stream_q [$];
    bit     tx_idle = 1'b1;
    int     random_sent = 0;

    // receiver side
    int     hold_asked  = 0;
    int     hold_served = 0;
    int     hold_left   = 0;
    int     gap_left    = 0;
    int     rx_gap;
    bit     rx_idle     = 1'b1;
    int     rx_cycles   = 0;
    int     quiet_cycles = 0;

    always #(PERIOD / 2) clk = ~clk;

    rle_byte_encoder_top DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_stall         (in_stall),
        .i_data_byte     (data_byte),
        .i_end_of_stream (end_of_stream),
        .o_valid         (out_valid),
        .i_stall         (out_stall),
        .o_out_word      (out_word),
        .o_out_bytes     (out_bytes),
        .o_item_done     (item_done),
        .o_stream_done   (stream_done)
    );

    rle_checker u_rle_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_data_byte     (data_byte),
        .i_end_of_stream (end_of_stream),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_word      (out_word),
        .i_out_bytes     (out_bytes),
        .i_item_done     (item_done),
        .i_stream_done   (stream_done),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    // Switch receiver idling on and off in stretches
    always @(posedge clk) begin
        rx_cycles <= rx_cycles + 1;
        if (rx_cycles % 64 == 0) rx_idle <= ($urandom_range(0, 3) != 0);
    end

    // Drive output stall: long hold-offs on request, random gaps after each beat
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= (hold_left > 1);
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_served + 1;
            hold_left   <= LONG_HOLD;
            out_stall   <= 1'b1;
        end else if (out_valid && !out_stall) begin
            rx_gap = rx_idle ? $urandom_range(0, 8) : 0;
            gap_left  <= rx_gap;
            out_stall <= (rx_gap > 0);
        end else if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            out_stall <= (gap_left > 1);
        end
    end

    // Watchdog: end the run when no beat moves on either channel for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one input beat after a random gap and hold it until accepted
    task automatic send_beat(input t_byte b, input logic eos);
        int gap;
        gap = tx_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_stream <= eos;
        do @(posedge clk); while (!(in_valid && !in_stall));
    endtask

    // Send the queued stream, flagging end of stream on its last byte
    task automatic send_stream();
        for (int i = 0; i < stream_q.size(); i++) begin
            send_beat(stream_q[i], i == stream_q.size() - 1);
        end
        stream_q.delete();
    endtask

    // Drop valid and wait until every predicted beat has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic queue_run(input t_byte value, input int len);
        repeat (len) stream_q.push_back(value);
    endtask

    // Queue bytes from [lo, hi] with no byte equal to the one before it
    task automatic queue_literal(input int len, input int lo, input int hi);
        t_byte b;
        repeat (len) begin
            do b = t_byte'($urandom_range(lo, hi));
            while (stream_q.size() > 0 && b == stream_q[$]);
            stream_q.push_back(b);
        end
    endtask

    // Build a stream of runs, literals and unshaped noise, sometimes over a narrow
    // alphabet so that short runs form on their own
    task automatic build_random_stream();
        int segs;
        int lo;
        int hi;
        int kind;
        bit long_seg;
        segs = $urandom_range(1, 5);
        if ($urandom_range(0, 1) == 1) begin
            lo = $urandom_range(0, 252);
            hi = lo + 3;
        end else begin
            lo = 0;
            hi = 255;
        end
        repeat (segs) begin
            kind     = $urandom_range(0, 2);
            long_seg = ($urandom_range(0, 15) == 0);
            case (kind)
                0: begin
                    queue_run(t_byte'($urandom_range(lo, hi)),
                              long_seg ? $urandom_range(120, 140) : $urandom_range(2, 9));
                end
                1: begin
                    queue_literal(long_seg ? $urandom_range(120, 140) : $urandom_range(1, 10),
                                  lo, hi);
                end
                default: begin
                    repeat ($urandom_range(1, 6)) stream_q.push_back(t_byte'($urandom_range(lo, hi)));
                end
            endcase
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // single bytes at both extremes: one-byte literals
        stream_q.push_back(8'h00);
        send_stream();
        stream_q.push_back(8'hFF);
        send_stream();
        // shortest run
        queue_run(8'hA5, 2);
        send_stream();
        // literal flushed when a run starts
        stream_q.push_back(8'h11);
        stream_q.push_back(8'h22);
        queue_run(8'h33, 3);
        send_stream();
        // run, then a literal whose last byte joins it at end of stream
        queue_run(8'h44, 2);
        stream_q.push_back(8'h55);
        stream_q.push_back(8'h66);
        send_stream();
        // header-like byte values inside a literal, then a run closed by end of stream
        stream_q.push_back(8'h80);
        stream_q.push_back(8'h7F);
        stream_q.push_back(8'h80);
        queue_run(8'hFF, 3);
        send_stream();

        // pause the sender until every result is out
        wait_drained();

        // run past the maximum length
        queue_run(t_byte'($urandom_range(0, 255)), $urandom_range(128, 132));
        random_sent += stream_q.size();
        send_stream();

        // a full literal sent back to back while the receiver holds off, so the
        // block backs up before the hold ends
        hold_asked <= hold_asked + 1;
        tx_idle = 1'b0;
        queue_literal($urandom_range(128, 130), 0, 255);
        random_sent += stream_q.size();
        send_stream();

        while (random_sent < RANDOM_ITEMS) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            build_random_stream();
            random_sent += stream_q.size();
            send_stream();
            if ($urandom_range(0, 3) == 0) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
